// ----- hw/rtl/mwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared widths, codes and types of the multi waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwg_pkg;

   localparam int NP_W        = 16;
   localparam int STEP_W      = 24;
   localparam int MODE_W      = 2;
   localparam int SAMPLE_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int MAG_W       = 15;
   localparam int QUO_W       = 14;
   localparam int DIVISOR_W   = 19;
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 15;
   localparam int NUMER_SHIFT = 16;
   localparam int PROD1_W     = 43;
   localparam int PROD2_W     = 33;
   localparam int DIV_STEPS   = 32;
   localparam int DIV_CNT_W   = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_SINE     = 2'd0,
      MODE_SQUARE   = 2'd1,
      MODE_SAWTOOTH = 2'd2,
      MODE_TRIANGLE = 2'd3
   } wave_mode_type;

   localparam logic [CSR_INDEX_W-1:0] REG_WAVE_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_POINTS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP = 2'd2;

   localparam logic [NP_W-1:0]   NUM_POINTS_RESET = 16'd256;
   localparam logic [NP_W-1:0]   NUM_POINTS_MIN   = 16'd2;
   localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 24'd65536;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      wave_mode_type   mode;
      logic            sq_high;
      logic            neg;
      logic [MAG_W-1:0] mag;
      logic [NP_W-1:0] index;
      logic            last;
   } pipe_word_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mwg_if.sv -----
// ----------------------------------------------------------------------------
// mwg channel interfaces
// Valid/ready channels for request words, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwg_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface mwg_rsp_if;
   import mwg_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [NP_W-1:0]            sample_index;
   logic                       last;
   modport source (output valid, output sample, output sample_index, output last,
                   input ready);
   modport sink   (input valid, input sample, input sample_index, input last,
                   output ready);
endinterface

interface mwg_csr_if;
   import mwg_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mwg_recip_div.sv -----
// ----------------------------------------------------------------------------
// mwg_recip_div
// Restoring divider that forms floor(2^31 / divisor), one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_recip_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mwg_pkg::DIVISOR_W-1:0] divisor,
   output logic                          busy,
   output logic [mwg_pkg::RECIP_W-1:0]   recip
);
   import mwg_pkg::*;

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [RECIP_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W:0]   rem_shift;
   logic                 fits;

   // dividend is a single one in its top bit
   always_comb begin
      rem_shift = {rem_ff, cnt_ff == '0};
      fits      = rem_shift >= {1'b0, divisor};
      rem_in    = fits ? DIVISOR_W'(rem_shift - {1'b0, divisor}) : rem_shift[DIVISOR_W-1:0];
      quo_in    = {quo_ff[RECIP_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy  = busy_ff;
   assign recip = quo_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mwg_sine_rom.sv -----
// ----------------------------------------------------------------------------
// mwg_sine_rom
// Quarter-wave sine table with quadrant folding and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_sine_rom #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [SINE_TABLE_BITS-1:0]          addr,
   output logic signed [mwg_pkg::SAMPLE_W-1:0] data
);
   import mwg_pkg::*;

   localparam int QBITS = SINE_TABLE_BITS - 2;
   localparam int QSIZE = 1 << QBITS;
   localparam logic [QBITS:0] QSIZE_V = (QBITS + 1)'(QSIZE);
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210};

   typedef logic [SAMPLE_W-1:0] qtab_type [QSIZE+1];

   // taylor series to x^15 in q30, rounded to q15
   function automatic logic [SAMPLE_W-1:0] quarter_sine(input longint unsigned r);
      longint unsigned x;
      longint unsigned t;
      longint          s;
      x = (r * HALF_PI_Q30) >> QBITS;
      t = x;
      s = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / TAYLOR_DIV[k-1];
         if (k[0]) begin
            s = s - longint'(t);
         end else begin
            s = s + longint'(t);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      s = (s + 64'sd16384) >>> 15;
      if (s > 64'sd32767) begin
         s = 64'sd32767;
      end
      return s[SAMPLE_W-1:0];
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type tab;
      for (int r = 0; r <= QSIZE; r++) begin
         tab[r] = quarter_sine(longint'(r));
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   logic [1:0]                 quad;
   logic [QBITS-1:0]           r;
   logic [QBITS:0]             qi;
   logic [SAMPLE_W-1:0]        mag;
   logic signed [SAMPLE_W-1:0] val;
   logic signed [SAMPLE_W-1:0] data_ff;

   always_comb begin
      quad = addr[SINE_TABLE_BITS-1 -: 2];
      r    = addr[QBITS-1:0];
      qi   = quad[0] ? QSIZE_V - {1'b0, r} : {1'b0, r};
      mag  = QTAB[qi];
      val  = quad[1] ? signed'(SAMPLE_W'(0) - mag) : signed'(mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= val;
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mwg_front.sv -----
// ----------------------------------------------------------------------------
// mwg_front
// Index and phase state, period bookkeeping and per-mode decode of a word.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_front #(
   parameter int PHASE_BITS      = 24,
   parameter int SINE_TABLE_BITS = 10,
   parameter int INDEX_BITS      = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           restart,
   input  logic [mwg_pkg::NP_W-1:0]       n_eff,
   input  logic [mwg_pkg::STEP_W-1:0]     phase_step,
   input  mwg_pkg::wave_mode_type         wave_mode,
   output mwg_pkg::pipe_word_type         word,
   output logic [SINE_TABLE_BITS-1:0]     sine_addr
);
   import mwg_pkg::*;

   localparam int CW = (INDEX_BITS > NP_W) ? INDEX_BITS : NP_W;

   logic [INDEX_BITS-1:0] idx_ff, idx_in, idx_start, idx_cur;
   logic [PHASE_BITS-1:0] ph_ff, ph_in, ph_cur;
   logic [NP_W-1:0]       i16, half, quarter, three_q;
   logic [NP_W+1:0]       n_x3;
   logic [NP_W:0]         i17, n17, two_i, mag17;
   logic                  is_last, neg;

   always_comb begin
      idx_start = restart ? '0 : idx_ff;
      ph_cur    = restart ? '0 : ph_ff;
      idx_cur   = (CW'(idx_start) < CW'(n_eff)) ? idx_start : '0;
      i16       = NP_W'(idx_cur);
      is_last   = i16 == (n_eff - 1'b1);

      half    = n_eff >> 1;
      quarter = n_eff >> 2;
      n_x3    = {2'b00, n_eff} + {1'b0, n_eff, 1'b0};
      three_q = n_x3[NP_W+1:2];
      i17     = {1'b0, i16};
      n17     = {1'b0, n_eff};
      two_i   = {i16, 1'b0};

      mag17 = '0;
      neg   = 1'b0;
      case (wave_mode)
         MODE_SAWTOOTH: begin
            if (i16 <= half) begin
               mag17 = i17;
            end else begin
               mag17 = n17 - i17;
               neg   = 1'b1;
            end
         end
         MODE_TRIANGLE: begin
            if (i16 <= quarter) begin
               mag17 = two_i;
            end else if (i16 <= three_q) begin
               if (two_i > n17) begin
                  mag17 = two_i - n17;
                  neg   = 1'b1;
               end else begin
                  mag17 = n17 - two_i;
               end
            end else begin
               mag17 = {n_eff - i16, 1'b0};
               neg   = 1'b1;
            end
         end
         default: begin
            mag17 = '0;
            neg   = 1'b0;
         end
      endcase

      word.mode    = wave_mode;
      word.sq_high = i16 < half;
      word.neg     = neg;
      word.mag     = mag17[MAG_W-1:0];
      word.index   = i16;
      word.last    = is_last;
   end

   if (PHASE_BITS >= SINE_TABLE_BITS) begin : g_addr_hi
      assign sine_addr = ph_cur[PHASE_BITS-1 -: SINE_TABLE_BITS];
   end else begin : g_addr_lo
      assign sine_addr = {ph_cur, {(SINE_TABLE_BITS - PHASE_BITS){1'b0}}};
   end

   // after the last sample of a period, index and phase return to zero
   always_comb begin
      idx_in = idx_ff;
      ph_in  = ph_ff;
      if (accept) begin
         if (is_last) begin
            idx_in = '0;
            ph_in  = '0;
         end else begin
            idx_in = idx_cur + 1'b1;
            ph_in  = ph_cur + PHASE_BITS'(phase_step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         ph_ff  <= '0;
      end else begin
         idx_ff <= idx_in;
         ph_ff  <= ph_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_waveform_generator_unit.sv -----
// ----------------------------------------------------------------------------
// multi_waveform_generator_unit
// Sine, square, sawtooth and triangle sample source, one word per cycle when not stalled.
// ----------------------------------------------------------------------------
// Every accepted request word yields one result word: a signed Q1.15 sample,
// its index within the period and a flag on the final sample. Words are taken
// one per cycle when not stalled, and each result is registered at the
// output; the rate comes from the two pipelined multiplier stages that
// divide the sawtooth and triangle values by five times the period through
// a stored reciprocal. That reciprocal comes from a bit-serial divider
// which runs after reset and after every write of num_points; req_ready
// stays low while it runs, while register writes are still taken.
`default_nettype none

module multi_waveform_generator_unit #(
   parameter int PHASE_BITS      = 24,
   parameter int SINE_TABLE_BITS = 10,
   parameter int INDEX_BITS      = 16
) (
   input  logic     clock,
   input  logic     reset,
   mwg_req_if.sink  req_ch,
   mwg_rsp_if.source rsp_ch,
   mwg_csr_if.sink  csr_ch
);
   import mwg_pkg::*;

   // registers
   wave_mode_type     wave_mode_ff;
   logic [NP_W-1:0]   num_points_ff;
   logic [STEP_W-1:0] phase_step_ff;
   logic              csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff  <= MODE_SINE;
         num_points_ff <= NUM_POINTS_RESET;
         phase_step_ff <= PHASE_STEP_RESET;
      end else if (csr_write) begin
         case (csr_ch.index)
            REG_WAVE_MODE:  wave_mode_ff  <= wave_mode_type'(csr_ch.data[MODE_W-1:0]);
            REG_NUM_POINTS: num_points_ff <= csr_ch.data[NP_W-1:0];
            REG_PHASE_STEP: phase_step_ff <= csr_ch.data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   logic [NP_W-1:0]      n_eff;
   logic [DIVISOR_W-1:0] divisor;

   assign n_eff   = (num_points_ff < NUM_POINTS_MIN) ? NUM_POINTS_MIN : num_points_ff;
   assign divisor = {n_eff, 2'b00} + DIVISOR_W'(n_eff);

   // reciprocal of five times the period
   logic               div_busy;
   logic [RECIP_W-1:0] recip;

   mwg_recip_div u_recip_div (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_write && (csr_ch.index == REG_NUM_POINTS)),
      .divisor (divisor),
      .busy    (div_busy),
      .recip   (recip)
   );

   // pipeline handshake
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic ld1, ld2, ld3, ld_o, accept;

   assign ld_o   = !vo_ff || rsp_ch.ready;
   assign ld3    = !v3_ff || ld_o;
   assign ld2    = !v2_ff || ld3;
   assign ld1    = !v1_ff || ld2;
   assign req_ch.ready = ld1 && !div_busy;
   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (ld1)  v1_ff <= accept;
         if (ld2)  v2_ff <= v1_ff;
         if (ld3)  v3_ff <= v2_ff;
         if (ld_o) vo_ff <= v3_ff;
      end
   end

   // decode
   pipe_word_type              word0;
   logic [SINE_TABLE_BITS-1:0] addr0;

   mwg_front #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .INDEX_BITS      (INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .restart    (req_ch.restart),
      .n_eff      (n_eff),
      .phase_step (phase_step_ff),
      .wave_mode  (wave_mode_ff),
      .word       (word0),
      .sine_addr  (addr0)
   );

   // stage 1
   pipe_word_type              p1_word_ff;
   logic [SINE_TABLE_BITS-1:0] p1_addr_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         p1_word_ff <= word0;
         p1_addr_ff <= addr0;
      end
   end

   // stage 2: magnitude times reciprocal, sine lookup
   pipe_word_type              p2_word_ff;
   logic [PROD1_W-1:0]         prod1_ff;
   logic signed [SAMPLE_W-1:0] p2_sine;

   mwg_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock (clock),
      .en    (ld2),
      .addr  (p1_addr_ff),
      .data  (p2_sine)
   );

   always_ff @(posedge clock) begin
      if (ld2) begin
         p2_word_ff <= p1_word_ff;
         prod1_ff   <= PROD1_W'(p1_word_ff.mag) * PROD1_W'(recip);
      end
   end

   // stage 3: back-multiply the quotient estimate
   pipe_word_type              p3_word_ff;
   logic [QUO_W-1:0]           q_est, q_est_ff;
   logic [PROD2_W-1:0]         prod2_ff;
   logic signed [SAMPLE_W-1:0] p3_sine_ff;

   assign q_est = prod1_ff[RECIP_SHIFT +: QUO_W];

   always_ff @(posedge clock) begin
      if (ld3) begin
         p3_word_ff <= p2_word_ff;
         q_est_ff   <= q_est;
         prod2_ff   <= PROD2_W'(q_est) * PROD2_W'(divisor);
         p3_sine_ff <= p2_sine;
      end
   end

   // stage 4: quotient correction, sign and mode select
   logic [PROD2_W-1:0]         numer, rem;
   logic [QUO_W-1:0]           quo;
   logic [SAMPLE_W-1:0]        q16;
   logic signed [SAMPLE_W-1:0] div_val, sample_in;

   always_comb begin
      numer   = PROD2_W'(p3_word_ff.mag) << NUMER_SHIFT;
      rem     = numer - prod2_ff;
      quo     = q_est_ff + QUO_W'(rem >= PROD2_W'(divisor));
      q16     = SAMPLE_W'(quo);
      div_val = p3_word_ff.neg ? signed'(SAMPLE_W'(0) - q16) : signed'(q16);
      case (p3_word_ff.mode)
         MODE_SINE:     sample_in = p3_sine_ff;
         MODE_SQUARE:   sample_in = p3_word_ff.sq_high ? SAMPLE_MAX : SAMPLE_MIN;
         MODE_SAWTOOTH: sample_in = div_val;
         MODE_TRIANGLE: sample_in = div_val;
         default:       sample_in = div_val;
      endcase
   end

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [NP_W-1:0]            index_ff;
   logic                       last_ff;

   always_ff @(posedge clock) begin
      if (ld_o) begin
         sample_ff <= sample_in;
         index_ff  <= p3_word_ff.index;
         last_ff   <= p3_word_ff.last;
      end
   end

   assign rsp_ch.valid        = vo_ff;
   assign rsp_ch.sample       = sample_ff;
   assign rsp_ch.sample_index = index_ff;
   assign rsp_ch.last         = last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mwg_checker.sv -----
// ----------------------------------------------------------------------------
// mwg_checker
// Port-level checks of the waveform generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [mwg_pkg::SAMPLE_W-1:0]    rsp_sample,
   input logic [mwg_pkg::NP_W-1:0]        rsp_sample_index,
   input logic                            rsp_last,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [mwg_pkg::CSR_INDEX_W-1:0] csr_index
);
   import mwg_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
         && $stable(rsp_sample_index) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // a period is at least two samples long
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_sample_index != '0)
      else $error("last flag on index zero");

   // reset empties the pipe and starts the reciprocal divider
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   // a new period length blocks requests while its reciprocal is formed
   a_np_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == REG_NUM_POINTS) |=> !req_ready)
      else $error("request taken during reciprocal update");

   // requests are never taken during reset recovery
   a_no_req_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !(req_valid && req_ready))
      else $error("request accepted right after reset");

endmodule

bind multi_waveform_generator_unit mwg_checker u_mwg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_sample       (rsp_ch.sample),
   .rsp_sample_index (rsp_ch.sample_index),
   .rsp_last         (rsp_ch.last),
   .csr_valid        (csr_ch.valid),
   .csr_ready        (csr_ch.ready),
   .csr_index        (csr_ch.index)
);

`default_nettype wire

// ----- tb/multi_waveform_generator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// multi_waveform_generator_unit_tb
// Self-checking bench for the sine, square, sawtooth and triangle generator.
// A behavioral sample predictor follows every accepted request word. Each
// result word is compared with the oldest prediction. Register settings
// change between phases, the request channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module multi_waveform_generator_unit_tb;
   import mwg_pkg::*;

   localparam int PHASE_BITS  = 24;
   localparam int LUT_BITS    = 10;
   localparam int LUT_SIZE    = 1 << LUT_BITS;
   localparam int QUARTER     = LUT_SIZE / 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [NP_W-1:0]            index;
      logic                       last;
   } sample_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mwg_req_if req_bus ();
   mwg_rsp_if rsp_bus ();
   mwg_csr_if csr_bus ();

   multi_waveform_generator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // predictor state and register copy
   logic signed [SAMPLE_W-1:0] sine_lut [LUT_SIZE];
   wave_mode_type              cfg_mode;
   logic [NP_W-1:0]            cfg_points;
   logic [STEP_W-1:0]          cfg_step;
   logic [NP_W-1:0]            index_count;
   logic [PHASE_BITS-1:0]      phase_sum;
   sample_word_type            pending_samples [$];

   int  errors       = 0;
   int  cycle_count  = 0;
   int  words_sent   = 0;
   int  words_seen   = 0;
   int  periods_seen = 0;
   int  reg_writes   = 0;
   int  hold_left    = 0;
   bit  quiet_mode   = 1'b0;

   always #6 clock = ~clock;

   function automatic logic signed [SAMPLE_W-1:0] quarter_sine(input longint unsigned r);
      longint unsigned x;
      longint unsigned t;
      longint          s;
      x = (r * HALF_PI_Q30) >> (LUT_BITS - 2);
      t = x;
      s = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) s = s - longint'(t);
         else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      s = (s + 16384) / 32768;
      if (s > 32767) s = 32767;
      return s[SAMPLE_W-1:0];
   endfunction

   function automatic sample_word_type next_sample(input logic restart);
      longint          n;
      longint          i;
      longint          d;
      longint          v;
      sample_word_type w;
      n = (cfg_points < 2) ? 2 : longint'(cfg_points);
      d = 5 * n;
      if (restart) begin
         index_count = '0;
         phase_sum   = '0;
      end
      if (longint'(index_count) >= n) index_count = '0;
      i = longint'(index_count);
      case (cfg_mode)
         MODE_SINE: v = sine_lut[phase_sum[PHASE_BITS-1 -: LUT_BITS]];
         MODE_SQUARE: v = (i < n / 2) ? 32767 : -32768;
         MODE_SAWTOOTH: begin
            if (i <= n / 2) v = (65536 * i) / d;
            else v = (65536 * (i - n)) / d;
         end
         default: begin
            if (i <= n / 4) v = (131072 * i) / d;
            else if (i <= (n * 3) / 4) v = (32768 * (2 * n - 4 * i)) / d;
            else v = (131072 * (i - n)) / d;
         end
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      w.sample = v[SAMPLE_W-1:0];
      w.index  = i[NP_W-1:0];
      w.last   = (i == n - 1);
      if (w.last) begin
         index_count = '0;
         phase_sum   = '0;
      end else begin
         index_count = index_count + 1'b1;
         phase_sum   = phase_sum + cfg_step;
      end
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 30) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input logic restart);
      if (!quiet_mode && $urandom_range(99) < 8) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.restart = restart;
      do @(posedge clock); while (!req_bus.ready);
      pending_samples.push_back(next_sample(restart));
      words_sent++;
      @(negedge clock);
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'($urandom);
   endtask

   task automatic send_burst(input int count, input logic first_restart);
      for (int k = 0; k < count; k++) send_word(k == 0 ? first_restart : 1'b0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         REG_WAVE_MODE:  cfg_mode   = wave_mode_type'(data[MODE_W-1:0]);
         REG_NUM_POINTS: cfg_points = data[NP_W-1:0];
         REG_PHASE_STEP: cfg_step   = data[STEP_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
      csr_bus.index = 2'($urandom);
      csr_bus.data  = 24'($urandom);
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_reset_state();
      send_burst(3, 1'b0);
   endtask

   task automatic test_short_periods();
      wait_idle();
      write_reg(REG_WAVE_MODE, {22'($urandom), MODE_SQUARE});
      write_reg(REG_NUM_POINTS, {8'($urandom), 16'd0});
      send_burst(2, 1'b0);
      wait_idle();
      write_reg(REG_NUM_POINTS, {8'($urandom), 16'd1});
      send_burst(2, 1'b1);
   endtask

   task automatic test_period_shrink();
      wait_idle();
      write_reg(REG_WAVE_MODE, {22'd0, MODE_SAWTOOTH});
      write_reg(REG_NUM_POINTS, {8'd0, 16'd65535});
      send_burst(6, 1'b1);
      wait_idle();
      write_reg(REG_NUM_POINTS, {8'hFF, 16'd3});
      send_burst(3, 1'b0);
   endtask

   task automatic test_triangle();
      wait_idle();
      write_reg(REG_WAVE_MODE, {22'($urandom), MODE_TRIANGLE});
      write_reg(REG_NUM_POINTS, {8'd0, 16'd5});
      send_burst(5, 1'b1);
   endtask

   task automatic test_phase_wrap();
      wait_idle();
      write_reg(REG_WAVE_MODE, {22'd0, MODE_SINE});
      write_reg(REG_NUM_POINTS, {8'd0, 16'd65535});
      write_reg(REG_PHASE_STEP, 24'hFFFFFF);
      send_burst(3, 1'b1);
      wait_idle();
      write_reg(REG_PHASE_STEP, 24'd0);
      send_burst(2, 1'b0);
      wait_idle();
      write_reg(REG_SPARE, 24'($urandom));
      send_burst(2, 1'b0);
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      write_reg(REG_WAVE_MODE, {22'd0, MODE_SAWTOOTH});
      write_reg(REG_NUM_POINTS, {8'd0, 16'd24});
      write_reg(REG_PHASE_STEP, 24'd699050);
      @(posedge clock);
      quiet_mode = 1'b1;
      hold_left  = 120;
      @(negedge clock);
      send_burst(64, 1'b1);
      @(posedge clock);
      quiet_mode = 1'b0;
      @(negedge clock);
   endtask

   task automatic test_random_phases(input int phases);
      int              pick;
      logic [NP_W-1:0] np;
      int              n_eff;
      logic [STEP_W-1:0] step;
      for (int p = 0; p < phases; p++) begin
         wait_idle();
         @(posedge clock);
         quiet_mode = (p == phases / 2);
         @(negedge clock);
         pick = $urandom_range(99);
         if (pick < 60) np = 16'($urandom_range(2, 40));
         else if (pick < 80) np = 16'($urandom_range(41, 600));
         else if (pick < 88) np = 16'($urandom);
         else if (pick < 94) np = 16'($urandom_range(0, 1));
         else np = 16'd65535;
         n_eff = (np < 2) ? 2 : int'(np);
         pick = $urandom_range(99);
         if (pick < 70) step = 24'((1 << 24) / n_eff);
         else if (pick < 80) step = 24'($urandom);
         else if (pick < 90) step = 24'd0;
         else step = 24'hFFFFFF;
         if ($urandom_range(99) < 85) write_reg(REG_WAVE_MODE, 24'($urandom));
         if ($urandom_range(99) < 80) write_reg(REG_NUM_POINTS, {8'($urandom), np});
         if ($urandom_range(99) < 80) write_reg(REG_PHASE_STEP, step);
         repeat ($urandom_range(100, 160)) send_word($urandom_range(99) < 4);
      end
   endtask

   // receiver side ready, with random stalls and a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready = quiet_mode || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      sample_word_type exp_word;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_seen++;
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected word index %0d", rsp_bus.sample_index));
         end else begin
            exp_word = pending_samples.pop_front();
            if (rsp_bus.sample !== exp_word.sample)
               report_mismatch($sformatf("sample %0d, expected %0d at index %0d",
                  rsp_bus.sample, exp_word.sample, exp_word.index));
            if (rsp_bus.sample_index !== exp_word.index)
               report_mismatch($sformatf("sample_index %0d, expected %0d",
                  rsp_bus.sample_index, exp_word.index));
            if (rsp_bus.last !== exp_word.last)
               report_mismatch($sformatf("last %b, expected %b at index %0d",
                  rsp_bus.last, exp_word.last, exp_word.index));
            if (exp_word.last) periods_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL multi_waveform_generator_unit");
         $finish;
      end
   end

   initial begin
      int quad;
      int r;
      logic signed [SAMPLE_W-1:0] v;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = REG_WAVE_MODE;
      csr_bus.data    = '0;
      for (int k = 0; k < LUT_SIZE; k++) begin
         quad = k / QUARTER;
         r    = k % QUARTER;
         v = (quad % 2 == 1) ? quarter_sine(QUARTER - r) : quarter_sine(r);
         sine_lut[k] = (quad >= 2) ? -v : v;
      end
      cfg_mode    = MODE_SINE;
      cfg_points  = NUM_POINTS_RESET;
      cfg_step    = PHASE_STEP_RESET;
      index_count = '0;
      phase_sum   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_short_periods();
      test_period_shrink();
      test_triangle();
      test_phase_wrap();
      test_output_backpressure();
      test_random_phases(14);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("sent %0d request words, checked %0d results over %0d full periods, %0d writes",
               words_sent, words_seen, periods_seen, reg_writes);
      $display("all wave modes, periods 0 to 65535, restarts, period shrink, phase wrap, stalls");
      if (errors == 0 && pending_samples.size() == 0) begin
         $display("PASS multi_waveform_generator_unit");
      end else begin
         $display("FAIL multi_waveform_generator_unit");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/mwg_pkg.sv
hw/rtl/mwg_if.sv
hw/rtl/mwg_recip_div.sv
hw/rtl/mwg_sine_rom.sv
hw/rtl/mwg_front.sv
hw/rtl/multi_waveform_generator_unit.sv
hw/rtl/mwg_checker.sv
tb/multi_waveform_generator_unit_tb.sv
